// ===== rtl/wavefront_reconstructor_mvm_core_assert.svh =====
// Assertion macros used by the reconstructor MVM top level.
`ifndef WAVEFRONT_RECONSTRUCTOR_MVM_CORE_ASSERT_SVH
`define WAVEFRONT_RECONSTRUCTOR_MVM_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WRMVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define WRMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wrmvm_pkg.sv =====
// Shared types and constants for the reconstructor MVM core.
package wrmvm_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_SLOPES = 128;
	localparam int DATA_WIDTH = 16;
	localparam int ACC_BITS   = 40;
	localparam int RES_BITS   = 24;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_SLOPES);
	localparam int CADDR_W = ROW_W + COL_W;
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int OIDX_W  = 6;

	// Half frame never exceeds this
	localparam logic [COL_W:0] HALF_MAX = (COL_W + 1)'(MAX_SLOPES / 2);

	// Command codes
	localparam logic CMD_COEFF = 1'b0;
	localparam logic CMD_SLOPE = 1'b1;

	// Result kinds
	localparam logic KIND_ACT  = 1'b0;
	localparam logic KIND_MODE = 1'b1;

	// Register indexes
	localparam logic [1:0] CFG_SUBAP_DIM = 2'd0;
	localparam logic [1:0] CFG_ACT_DIM   = 2'd1;
	localparam logic [1:0] CFG_N_MODES   = 2'd2;
	localparam logic [1:0] CFG_OUT_SHIFT = 2'd3;

	// Tag that travels with each multiply-accumulate term
	typedef struct packed {
		logic              first;   // first term of a row
		logic              lastt;   // last term of a row
		logic              neg;     // subtract this product
		logic              zero;    // product forced to zero
		logic              kind;
		logic [OIDX_W-1:0] oidx;
		logic              eor;     // last term of the frame
	} term_tag_t;

endpackage

// ===== rtl/wrmvm_store.sv =====
// Coefficient memory and slope frame buffer, with registered reads.
module wrmvm_store (
	input  logic                                 clk,
	input  logic                                 coeff_we,
	input  logic                                 slope_we,
	input  logic [wrmvm_pkg::ROW_W-1:0]          wr_row,
	input  logic [wrmvm_pkg::COL_W-1:0]          wr_col,
	input  logic signed [wrmvm_pkg::DATA_WIDTH-1:0] wr_data,
	input  logic [wrmvm_pkg::CADDR_W-1:0]        coeff_raddr,
	input  logic [wrmvm_pkg::COL_W-1:0]          slope_raddr,
	output logic signed [wrmvm_pkg::DATA_WIDTH-1:0] coeff_rd,
	output logic signed [wrmvm_pkg::DATA_WIDTH-1:0] slope_rd
);

	logic [wrmvm_pkg::DATA_WIDTH-1:0] coeff_mem [wrmvm_pkg::MAX_ROWS*wrmvm_pkg::MAX_SLOPES];
	logic [wrmvm_pkg::DATA_WIDTH-1:0] slope_mem [wrmvm_pkg::MAX_SLOPES];

	// Coefficient memory, row-major
	always_ff @(posedge clk) begin
		if (coeff_we) begin
			coeff_mem[{wr_row, wr_col}] <= wr_data;
		end
		coeff_rd <= coeff_mem[coeff_raddr];
	end

	// Slope buffer: x slopes low half, y slopes high half
	always_ff @(posedge clk) begin
		if (slope_we) begin
			slope_mem[wr_col] <= wr_data;
		end
		slope_rd <= slope_mem[slope_raddr];
	end

endmodule

// ===== rtl/wrmvm_seq.sv =====
// Term sequencer: walks rows and columns, issues memory reads and tags.
module wrmvm_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic [3:0]                         subap_dim,
	input  logic [2:0]                         act_dim,
	input  logic [3:0]                         n_modes,
	output logic                               active,
	output logic                               issue_vld,
	output wrmvm_pkg::term_tag_t               issue_tag,
	output logic [wrmvm_pkg::CADDR_W-1:0]      coeff_raddr,
	output logic [wrmvm_pkg::COL_W-1:0]        slope_raddr
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ZONAL = 2'd1;
	localparam logic [1:0] PH_MODAL = 2'd2;

	localparam int CW = wrmvm_pkg::COL_W;

	logic [1:0]                      phase_q;
	logic [CW-1:0]                   t_q;
	logic [CW:0]                     half_q;
	logic [wrmvm_pkg::ROW_W:0]       r_q;
	logic [2:0]                      i_q;
	logic [2:0]                      j_q;
	logic [wrmvm_pkg::OIDX_W-1:0]    oidx_q;
	logic [3:0]                      m_q;

	logic [7:0]    sq;
	logic [CW:0]   half_new;
	logic [CW-1:0] t_last;
	logic          term_last;
	logic          t_lo;
	logic          j_end;
	logic          i_end;
	logic          m_end;
	logic          row_is_final;

	// Half frame size, clamped
	assign sq       = {4'd0, subap_dim} * {4'd0, subap_dim};
	assign half_new = (sq > 8'(wrmvm_pkg::HALF_MAX)) ? wrmvm_pkg::HALF_MAX : (CW + 1)'(sq);

	// Last term of a row: at least one term so an empty row still reports
	assign t_last    = (half_q == '0) ? '0 : CW'({half_q, 1'b0} - 1'b1);
	assign term_last = (t_q == t_last);
	assign t_lo      = ({1'b0, t_q} < half_q);

	assign j_end = (j_q == act_dim - 3'd1);
	assign i_end = (i_q == act_dim - 3'd1);
	assign m_end = (m_q == n_modes - 4'd1);
	assign row_is_final = (phase_q == PH_ZONAL) ? (i_end && j_end && n_modes == '0) : m_end;

	assign active    = (phase_q != PH_IDLE);
	assign issue_vld = active;

	// Read addresses: coefficient column is the term count
	always_comb begin
		coeff_raddr = {r_q[wrmvm_pkg::ROW_W-1:0], t_q};
		if (phase_q == PH_ZONAL) begin
			slope_raddr = t_lo ? CW'({1'b0, t_q} + half_q) : CW'({1'b0, t_q} - half_q);
		end else begin
			slope_raddr = t_q;
		end
	end

	// Term tag
	always_comb begin
		issue_tag.first = (t_q == '0);
		issue_tag.lastt = term_last;
		issue_tag.neg   = (phase_q == PH_ZONAL) ? !t_lo : 1'b1;
		issue_tag.zero  = r_q[wrmvm_pkg::ROW_W] || (half_q == '0);
		issue_tag.kind  = (phase_q == PH_ZONAL) ? wrmvm_pkg::KIND_ACT : wrmvm_pkg::KIND_MODE;
		issue_tag.oidx  = (phase_q == PH_ZONAL) ? oidx_q : wrmvm_pkg::OIDX_W'(m_q);
		issue_tag.eor   = term_last && row_is_final;
	end

	// Row and term counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			t_q     <= '0;
			half_q  <= '0;
			r_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			oidx_q  <= '0;
			m_q     <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (go) begin
						phase_q <= (act_dim != '0) ? PH_ZONAL : PH_MODAL;
						half_q  <= half_new;
						t_q     <= '0;
						r_q     <= '0;
						i_q     <= '0;
						j_q     <= '0;
						oidx_q  <= '0;
						m_q     <= '0;
					end
				end
				PH_ZONAL: begin
					if (term_last) begin
						t_q <= '0;
						r_q <= r_q + 1'b1;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								phase_q <= (n_modes != '0) ? PH_MODAL : PH_IDLE;
								m_q     <= '0;
							end else begin
								i_q    <= i_q + 3'd1;
								oidx_q <= wrmvm_pkg::OIDX_W'(i_q + 3'd1);
							end
						end else begin
							j_q    <= j_q + 3'd1;
							oidx_q <= oidx_q + wrmvm_pkg::OIDX_W'(act_dim);
						end
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				PH_MODAL: begin
					if (term_last) begin
						t_q <= '0;
						r_q <= r_q + 1'b1;
						m_q <= m_q + 4'd1;
						if (m_end) begin
							phase_q <= PH_IDLE;
						end
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/wrmvm_mac.sv =====
// Multiply-accumulate pipeline with shift, saturation and result register.
module wrmvm_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    issue_vld,
	input  wrmvm_pkg::term_tag_t                    issue_tag,
	input  logic signed [wrmvm_pkg::DATA_WIDTH-1:0] coeff_rd,
	input  logic signed [wrmvm_pkg::DATA_WIDTH-1:0] slope_rd,
	input  logic [4:0]                              out_shift,
	output logic                                    pipe_busy,
	output logic                                    result_valid,
	output logic                                    kind,
	output logic [wrmvm_pkg::OIDX_W-1:0]            out_index,
	output logic signed [wrmvm_pkg::RES_BITS-1:0]   result_value,
	output logic                                    saturated,
	output logic                                    end_of_run
);

	localparam int AW = wrmvm_pkg::ACC_BITS;
	localparam int PW = wrmvm_pkg::PROD_W;
	localparam int RW = wrmvm_pkg::RES_BITS;

	logic                  vld_s1, vld_s2, fin_s3;
	wrmvm_pkg::term_tag_t  tag_s1, tag_s2, tag_s3;
	logic signed [PW-1:0]  prod_s2;
	logic signed [AW-1:0]  acc_q;
	logic signed [AW-1:0]  prod_ext;
	logic signed [AW-1:0]  acc_base;
	logic signed [AW-1:0]  shifted;
	logic                  pos_ovf, neg_ovf;

	// Stage 1: tag lines up with memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue_vld;
			vld_s2 <= vld_s1;
			fin_s3 <= vld_s2 && tag_s2.lastt;
		end
	end

	// Stage 2: product register
	always_ff @(posedge clk) begin
		tag_s1  <= issue_tag;
		tag_s2  <= tag_s1;
		prod_s2 <= tag_s1.zero ? '0 : PW'(coeff_rd * slope_rd);
	end

	// Stage 3: 40-bit wrapping accumulator
	assign prod_ext = AW'(prod_s2);
	assign acc_base = tag_s2.first ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q  <= tag_s2.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
			tag_s3 <= tag_s2;
		end
	end

	// Arithmetic shift (floor) and clip to result width
	assign shifted = acc_q >>> out_shift;
	assign pos_ovf = !shifted[AW-1] && (|shifted[AW-2:RW-1]);
	assign neg_ovf = shifted[AW-1] && !(&shifted[AW-2:RW-1]);

	// Stage 4: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= fin_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s3) begin
			kind       <= tag_s3.kind;
			out_index  <= tag_s3.oidx;
			end_of_run <= tag_s3.eor;
			saturated  <= pos_ovf || neg_ovf;
			if (pos_ovf) begin
				result_value <= {1'b0, {(RW-1){1'b1}}};
			end else if (neg_ovf) begin
				result_value <= {1'b1, {(RW-1){1'b0}}};
			end else begin
				result_value <= shifted[RW-1:0];
			end
		end
	end

	assign pipe_busy = vld_s1 || vld_s2 || fin_s3 || result_valid;

endmodule

// ===== rtl/wavefront_reconstructor_mvm_core.sv =====
// Top level of the reconstructor matrix-vector multiply core.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  command   | start / busy       | cmd, row, col, value, last
//  config    | cfg_we             | cfg_idx, cfg_data
//  result    | result_valid       | kind, out_index, result_value, saturated,
//            |                    | end_of_run
//
// Coefficient writes and slopes without last never raise busy.
// A last slope runs the frame unless act_dim and n_modes are both zero: one MAC
// per cycle through the single coefficient read port, max(2*half,1) terms per row
// for act_dim^2 + n_modes rows; busy stays high until the final result beat.
// Results come out one beat per row and cannot be stalled.
// Reset clears control and sets the configuration defaults only; memory contents are undefined.
`include "wavefront_reconstructor_mvm_core_assert.svh"

module wavefront_reconstructor_mvm_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    cmd,
	input  logic [wrmvm_pkg::ROW_W-1:0]             row,
	input  logic [wrmvm_pkg::COL_W-1:0]             col,
	input  logic signed [wrmvm_pkg::DATA_WIDTH-1:0] value,
	input  logic                                    last,
	input  logic                                    cfg_we,
	input  logic [1:0]                              cfg_idx,
	input  logic [4:0]                              cfg_data,
	output logic                                    result_valid,
	output logic                                    kind,
	output logic [wrmvm_pkg::OIDX_W-1:0]            out_index,
	output logic signed [wrmvm_pkg::RES_BITS-1:0]   result_value,
	output logic                                    saturated,
	output logic                                    end_of_run
);

	logic [3:0] subap_dim_q;
	logic [2:0] act_dim_q;
	logic [3:0] n_modes_q;
	logic [4:0] out_shift_q;

	logic                                    accept;
	logic                                    go;
	logic                                    seq_active;
	logic                                    pipe_busy;
	logic                                    issue_vld;
	wrmvm_pkg::term_tag_t                    issue_tag;
	logic [wrmvm_pkg::CADDR_W-1:0]           coeff_raddr;
	logic [wrmvm_pkg::COL_W-1:0]             slope_raddr;
	logic signed [wrmvm_pkg::DATA_WIDTH-1:0] coeff_rd;
	logic signed [wrmvm_pkg::DATA_WIDTH-1:0] slope_rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subap_dim_q <= 4'd8;
			act_dim_q   <= 3'd7;
			n_modes_q   <= 4'd0;
			out_shift_q <= 5'd15;
		end else if (cfg_we) begin
			case (cfg_idx)
				wrmvm_pkg::CFG_SUBAP_DIM: subap_dim_q <= cfg_data[3:0];
				wrmvm_pkg::CFG_ACT_DIM:   act_dim_q   <= cfg_data[2:0];
				wrmvm_pkg::CFG_N_MODES:   n_modes_q   <= cfg_data[3:0];
				wrmvm_pkg::CFG_OUT_SHIFT: out_shift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command decode; empty configuration starts nothing
	assign accept = start && !busy;
	assign go     = accept && (cmd == wrmvm_pkg::CMD_SLOPE) && last &&
	                ((act_dim_q != '0) || (n_modes_q != '0));
	assign busy   = seq_active || pipe_busy;

	wrmvm_store u_store (
		.clk         (clk),
		.coeff_we    (accept && (cmd == wrmvm_pkg::CMD_COEFF)),
		.slope_we    (accept && (cmd == wrmvm_pkg::CMD_SLOPE)),
		.wr_row      (row),
		.wr_col      (col),
		.wr_data     (value),
		.coeff_raddr (coeff_raddr),
		.slope_raddr (slope_raddr),
		.coeff_rd    (coeff_rd),
		.slope_rd    (slope_rd)
	);

	wrmvm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.subap_dim   (subap_dim_q),
		.act_dim     (act_dim_q),
		.n_modes     (n_modes_q),
		.active      (seq_active),
		.issue_vld   (issue_vld),
		.issue_tag   (issue_tag),
		.coeff_raddr (coeff_raddr),
		.slope_raddr (slope_raddr)
	);

	wrmvm_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue_vld    (issue_vld),
		.issue_tag    (issue_tag),
		.coeff_rd     (coeff_rd),
		.slope_rd     (slope_rd),
		.out_shift    (out_shift_q),
		.pipe_busy    (pipe_busy),
		.result_valid (result_valid),
		.kind         (kind),
		.out_index    (out_index),
		.result_value (result_value),
		.saturated    (saturated),
		.end_of_run   (end_of_run)
	);

	// Frame-level checks
	`WRMVM_ASSERT_NEXT(a_frame_starts, go, busy, "frame start did not raise busy")
	`WRMVM_ASSERT_NOW(a_result_in_run, result_valid, busy, "result beat outside a run")
	`WRMVM_ASSERT_NEXT(a_eor_final, result_valid && end_of_run, !result_valid && !busy,
		"activity after final result of frame")

endmodule

// ===== sim/wavefront_reconstructor_mvm_core_tb.sv =====
// Self-checking testbench for the reconstructor MVM core: directed and random frames.
`timescale 1ns / 1ps

module wavefront_reconstructor_mvm_core_tb;

	localparam int IDLE_GAP    = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 470;
	localparam int PLAN_LEN    = 6;

	localparam logic signed [wrmvm_pkg::DATA_WIDTH-1:0] V_MIN =
		{1'b1, {(wrmvm_pkg::DATA_WIDTH-1){1'b0}}};
	localparam logic signed [wrmvm_pkg::DATA_WIDTH-1:0] V_MAX =
		{1'b0, {(wrmvm_pkg::DATA_WIDTH-1){1'b1}}};
	localparam longint RES_HI = (longint'(1) <<< (wrmvm_pkg::RES_BITS - 1)) - 1;
	localparam longint RES_LO = -RES_HI - 1;

	typedef struct packed {
		logic                                    cmd;
		logic [wrmvm_pkg::ROW_W-1:0]             row;
		logic [wrmvm_pkg::COL_W-1:0]             col;
		logic signed [wrmvm_pkg::DATA_WIDTH-1:0] value;
		logic                                    last;
	} cmd_beat_t;

	typedef struct packed {
		logic                                  kind;
		logic [wrmvm_pkg::OIDX_W-1:0]          idx;
		logic signed [wrmvm_pkg::RES_BITS-1:0] value;
		logic                                  sat;
		logic                                  eor;
	} result_beat_t;

	logic                                    clk      = 1'b0;
	logic                                    arst_n   = 1'b0;
	logic                                    start    = 1'b0;
	logic                                    cmd      = 1'b0;
	logic [wrmvm_pkg::ROW_W-1:0]             row      = '0;
	logic [wrmvm_pkg::COL_W-1:0]             col      = '0;
	logic signed [wrmvm_pkg::DATA_WIDTH-1:0] value    = '0;
	logic                                    last     = 1'b0;
	logic                                    cfg_we   = 1'b0;
	logic [1:0]                              cfg_idx  = '0;
	logic [4:0]                              cfg_data = '0;
	logic                                    busy;
	logic                                    result_valid;
	logic                                    kind;
	logic [wrmvm_pkg::OIDX_W-1:0]            out_index;
	logic signed [wrmvm_pkg::RES_BITS-1:0]   result_value;
	logic                                    saturated;
	logic                                    end_of_run;

	// register shadow, used both when building frames and when predicting them
	int unsigned subap_dim_q = 8;
	int unsigned act_dim_q   = 7;
	int unsigned n_modes_q   = 0;
	int unsigned out_shift_q = 15;

	// predicted memory contents
	logic signed [wrmvm_pkg::DATA_WIDTH-1:0] coeff_img [wrmvm_pkg::MAX_ROWS][wrmvm_pkg::MAX_SLOPES];
	logic signed [wrmvm_pkg::DATA_WIDTH-1:0] slope_img [wrmvm_pkg::MAX_SLOPES];

	// entries already covered by a queued write
	bit coeff_loaded [wrmvm_pkg::MAX_ROWS][wrmvm_pkg::MAX_SLOPES];
	bit slope_loaded [wrmvm_pkg::MAX_SLOPES];

	cmd_beat_t    cmd_queue[$];
	result_beat_t expected_results[$];
	int           fail_count   = 0;
	int           beats_queued = 0;
	bit           quiet        = 1'b0;
	int unsigned  stall_cycles = 0;

	wavefront_reconstructor_mvm_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.row(row),
		.col(col),
		.value(value),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.kind(kind),
		.out_index(out_index),
		.result_value(result_value),
		.saturated(saturated),
		.end_of_run(end_of_run)
	);

	always #5 clk = ~clk;

	// half frame length, clamped to the slope buffer
	function automatic int unsigned half_len();
		int unsigned h;
		h = subap_dim_q * subap_dim_q;
		return (h > wrmvm_pkg::MAX_SLOPES / 2) ? wrmvm_pkg::MAX_SLOPES / 2 : h;
	endfunction

	// mostly uniform, with the extremes weighted up
	function automatic logic signed [wrmvm_pkg::DATA_WIDTH-1:0] pick_value();
		case ($urandom_range(7))
			0: return V_MIN;
			1: return V_MAX;
			default: return wrmvm_pkg::DATA_WIDTH'($urandom);
		endcase
	endfunction

	// floor shift then clip to the result width
	function automatic result_beat_t shape_result(logic k, int unsigned idx, longint acc, bit eor);
		result_beat_t rb;
		longint sh;
		sh = acc >>> out_shift_q;
		rb.kind = k;
		rb.idx = wrmvm_pkg::OIDX_W'(idx);
		rb.eor = eor;
		rb.sat = 1'b0;
		if (sh > RES_HI) begin
			sh = RES_HI;
			rb.sat = 1'b1;
		end else if (sh < RES_LO) begin
			sh = RES_LO;
			rb.sat = 1'b1;
		end
		rb.value = wrmvm_pkg::RES_BITS'(sh);
		return rb;
	endfunction

	// zonal rows in transposed order, then the projected modes
	task automatic reconstruct_frame();
		int unsigned half, zonal, total, n, i, j, k, m, r;
		longint acc;
		half = half_len();
		zonal = act_dim_q * act_dim_q;
		total = zonal + n_modes_q;
		n = 0;
		for (i = 0; i < act_dim_q; i++) begin
			for (j = 0; j < act_dim_q; j++) begin
				r = i * act_dim_q + j;
				acc = 0;
				for (k = 0; k < half; k++) begin
					acc += longint'(coeff_img[r][k]) * longint'(slope_img[half + k]);
					acc -= longint'(coeff_img[r][half + k]) * longint'(slope_img[k]);
				end
				expected_results.insert(expected_results.size(),
					shape_result(wrmvm_pkg::KIND_ACT, j * act_dim_q + i, acc,
					n == total - 1));
				n++;
			end
		end
		for (m = 0; m < n_modes_q; m++) begin
			acc = 0;
			for (k = 0; k < 2 * half; k++)
				acc -= longint'(coeff_img[zonal + m][k]) * longint'(slope_img[k]);
			expected_results.insert(expected_results.size(),
				shape_result(wrmvm_pkg::KIND_MODE, m, acc, n == total - 1));
			n++;
		end
	endtask

	// update the predicted memories with one accepted beat
	task automatic apply_beat(logic b_cmd, logic [wrmvm_pkg::ROW_W-1:0] b_row,
			logic [wrmvm_pkg::COL_W-1:0] b_col,
			logic signed [wrmvm_pkg::DATA_WIDTH-1:0] b_value, logic b_last);
		if (b_cmd == wrmvm_pkg::CMD_COEFF) begin
			coeff_img[b_row][b_col] = b_value;
		end else begin
			slope_img[b_col] = b_value;
			if (b_last)
				reconstruct_frame();
		end
	endtask

	task automatic push_beat(logic b_cmd, logic [wrmvm_pkg::ROW_W-1:0] b_row,
			logic [wrmvm_pkg::COL_W-1:0] b_col,
			logic signed [wrmvm_pkg::DATA_WIDTH-1:0] b_value, logic b_last);
		cmd_beat_t b;
		b.cmd = b_cmd;
		b.row = b_row;
		b.col = b_col;
		b.value = b_value;
		b.last = b_last;
		cmd_queue.insert(cmd_queue.size(), b);
		if (b_cmd == wrmvm_pkg::CMD_COEFF)
			coeff_loaded[b_row][b_col] = 1'b1;
		else
			slope_loaded[b_col] = 1'b1;
		beats_queued++;
	endtask

	// one frame: noise, missing coefficients, slopes, then the closing slope
	task automatic gen_frame();
		int unsigned span, rows, n, r, c, k;
		span = 2 * half_len();
		rows = act_dim_q * act_dim_q + n_modes_q;
		// stray coefficient writes anywhere, last flag at random
		n = $urandom_range(3);
		repeat (n)
			push_beat(wrmvm_pkg::CMD_COEFF, wrmvm_pkg::ROW_W'($urandom),
				wrmvm_pkg::COL_W'($urandom), pick_value(), 1'($urandom));
		// new values for a few coefficients in use
		if (rows != 0 && span != 0) begin
			n = $urandom_range(2);
			repeat (n)
				push_beat(wrmvm_pkg::CMD_COEFF, wrmvm_pkg::ROW_W'($urandom_range(rows - 1)),
					wrmvm_pkg::COL_W'($urandom_range(span - 1)), pick_value(), 1'b0);
		end
		// everything the frame reads gets loaded first
		for (r = 0; r < rows; r++)
			for (c = 0; c < span; c++)
				if (!coeff_loaded[r][c])
					push_beat(wrmvm_pkg::CMD_COEFF, wrmvm_pkg::ROW_W'(r),
						wrmvm_pkg::COL_W'(c), pick_value(), 1'($urandom));
		for (k = 0; k < span; k++)
			if (!slope_loaded[k] || $urandom_range(3) == 0)
				push_beat(wrmvm_pkg::CMD_SLOPE, wrmvm_pkg::ROW_W'($urandom),
					wrmvm_pkg::COL_W'(k), pick_value(), 1'b0);
		// broken sequence: stray slope, no last
		if ($urandom_range(3) == 0)
			push_beat(wrmvm_pkg::CMD_SLOPE, wrmvm_pkg::ROW_W'($urandom),
				wrmvm_pkg::COL_W'($urandom), pick_value(), 1'b0);
		if (span != 0 && $urandom_range(1) == 1)
			push_beat(wrmvm_pkg::CMD_SLOPE, wrmvm_pkg::ROW_W'($urandom),
				wrmvm_pkg::COL_W'($urandom_range(span - 1)), pick_value(), 1'b1);
		else
			push_beat(wrmvm_pkg::CMD_SLOPE, wrmvm_pkg::ROW_W'($urandom),
				wrmvm_pkg::COL_W'($urandom), pick_value(), 1'b1);
	endtask

	// block idle: nothing queued, held or expected, then the pipeline drains
	task automatic wait_idle();
		while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
		while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// unused upper data bits get junk
	task automatic write_reg(logic [1:0] idx, int unsigned v, int unsigned w);
		logic [4:0] m;
		m = 5'((1 << w) - 1);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= (5'($urandom) & ~m) | (5'(v) & m);
	endtask

	task automatic write_config(int unsigned sd, int unsigned ad, int unsigned nm,
			int unsigned sh);
		wait_idle();
		write_reg(wrmvm_pkg::CFG_SUBAP_DIM, sd, 4);
		write_reg(wrmvm_pkg::CFG_ACT_DIM, ad, 3);
		write_reg(wrmvm_pkg::CFG_N_MODES, nm, 4);
		write_reg(wrmvm_pkg::CFG_OUT_SHIFT, sh, 5);
		@(posedge clk);
		cfg_we <= 1'b0;
		subap_dim_q = sd;
		act_dim_q = ad;
		n_modes_q = nm;
		out_shift_q = sh;
	endtask

	// command driver: predicts each accepted beat, then offers the next one
	always @(posedge clk) begin : drive_commands
		cmd_beat_t nxt;
		if (arst_n) begin
			if (start && !busy)
				apply_beat(cmd, row, col, value, last);
			if (!start || !busy) begin
				if (cmd_queue.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
					nxt = cmd_queue.pop_front();
					cmd <= nxt.cmd;
					row <= nxt.row;
					col <= nxt.col;
					value <= nxt.value;
					last <= nxt.last;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: each beat against the oldest prediction
	always @(posedge clk) begin : check_results
		result_beat_t want;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: index %0d value %0d", out_index, result_value);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (want.kind !== kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					fail_count++;
				end
				if (want.idx !== out_index) begin
					$error("out_index: expected %0d, got %0d", want.idx, out_index);
					fail_count++;
				end
				if (want.value !== result_value) begin
					$error("result_value: expected %0d, got %0d", $signed(want.value),
						result_value);
					fail_count++;
				end
				if (want.sat !== saturated) begin
					$error("saturated: expected %0d, got %0d", want.sat, saturated);
					fail_count++;
				end
				if (want.eor !== end_of_run) begin
					$error("end_of_run: expected %0d, got %0d", want.eor, end_of_run);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat of any kind
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned ph, frames, r, c;
		int unsigned plan_subap [PLAN_LEN] = '{2, 15, 1, 1, 3, 0};
		int unsigned plan_act   [PLAN_LEN] = '{3, 1, 5, 1, 1, 2};
		int unsigned plan_modes [PLAN_LEN] = '{2, 0, 0, 15, 1, 1};
		int unsigned plan_shift [PLAN_LEN] = '{12, 31, 0, 8, 20, 5};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: two slopes per frame, four actuators, two modes, no shift
		write_config(1, 2, 2, 0);
		push_beat(wrmvm_pkg::CMD_COEFF, '0, '0, V_MIN, 1'b1);
		push_beat(wrmvm_pkg::CMD_COEFF, '0, wrmvm_pkg::COL_W'(1), V_MAX, 1'b0);
		for (r = 1; r < 6; r++)
			for (c = 0; c < 2; c++)
				push_beat(wrmvm_pkg::CMD_COEFF, wrmvm_pkg::ROW_W'(r), wrmvm_pkg::COL_W'(c),
					pick_value(), 1'b0);
		// top corner of the address space, never read
		push_beat(wrmvm_pkg::CMD_COEFF, wrmvm_pkg::ROW_W'(wrmvm_pkg::MAX_ROWS - 1),
			wrmvm_pkg::COL_W'(wrmvm_pkg::MAX_SLOPES - 1), V_MAX, 1'b0);
		push_beat(wrmvm_pkg::CMD_SLOPE, wrmvm_pkg::ROW_W'(wrmvm_pkg::MAX_ROWS - 1),
			wrmvm_pkg::COL_W'(wrmvm_pkg::MAX_SLOPES - 1), V_MIN, 1'b0);
		// both slopes at the negative extreme, then y at the positive one
		push_beat(wrmvm_pkg::CMD_SLOPE, '0, '0, V_MIN, 1'b0);
		push_beat(wrmvm_pkg::CMD_SLOPE, '0, wrmvm_pkg::COL_W'(1), V_MIN, 1'b1);
		push_beat(wrmvm_pkg::CMD_SLOPE, '0, wrmvm_pkg::COL_W'(1), V_MAX, 1'b1);
		push_beat(wrmvm_pkg::CMD_SLOPE, '0, '0, '0, 1'b1);

		// empty grid: a closing slope yields nothing
		write_config(1, 0, 0, 15);
		push_beat(wrmvm_pkg::CMD_SLOPE, '0, '0, V_MAX, 1'b1);

		// random phases: planned corners first, then random small grids
		for (ph = 0; ph < PLAN_LEN || beats_queued < ITEM_TARGET; ph++) begin
			if (ph < PLAN_LEN)
				write_config(plan_subap[ph], plan_act[ph], plan_modes[ph], plan_shift[ph]);
			else
				write_config($urandom_range(3), $urandom_range(3), $urandom_range(4),
					$urandom_range(31));
			quiet = (ph == 2);
			// a full-length frame is loaded only once
			frames = (half_len() >= wrmvm_pkg::MAX_SLOPES / 2) ? 1 : 3 + $urandom_range(3);
			repeat (frames) gen_frame();
		end

		wait_idle();
		if (expected_results.size() != 0) begin
			$error("%0d predicted results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
